FILE: src/rotation_matrix_to_euler_angles_defines.svh
// Assertion macros for the rotation matrix to Euler angles block
`ifndef ROTATION_MATRIX_TO_EULER_ANGLES_DEFINES_SVH
`define ROTATION_MATRIX_TO_EULER_ANGLES_DEFINES_SVH

// same-cycle implication, off during reset
`define RMEA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off during reset
`define RMEA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/rmea_pkg.sv
// Shared types and constants for the rotation matrix to Euler angles block
`default_nettype none
package rmea_pkg;
	localparam int SQRT_STEPS   = 32;
	localparam int CORDIC_STEPS = 30;
	localparam int CW           = 56;  // CORDIC x/y datapath width
	localparam int AW           = 35;  // Q2.30 angle accumulator width

	localparam logic signed [AW-1:0] PI_Q30    = 35'sd3373259426;
	localparam logic signed [31:0]   ANG_MAX   = 32'sd1686629713;
	localparam logic [30:0]          THR_RESET = 31'd1074;

	localparam logic [29:0] ATAN_TAB [0:CORDIC_STEPS-1] = '{
		30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
		30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
		30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535,
		30'd32767, 30'd16383, 30'd8191, 30'd4095, 30'd2047,
		30'd1023, 30'd511, 30'd255, 30'd127, 30'd63,
		30'd31, 30'd15, 30'd7, 30'd3, 30'd1
	};

	typedef struct packed {
		logic signed [31:0] r00;
		logic signed [31:0] r10;
		logic signed [31:0] r11;
		logic signed [31:0] r12;
		logic signed [31:0] r20;
		logic signed [31:0] r21;
		logic signed [31:0] r22;
	} matrix_t;

	typedef struct packed {
		logic signed [31:0] angle_x;
		logic signed [31:0] angle_y;
		logic signed [31:0] angle_z;
		logic               singular;
	} angles_t;

	// atan2 operands, same scale, plus one sideband bit
	typedef struct packed {
		logic signed [32:0] y;
		logic signed [32:0] x;
		logic               tag;
	} cord_in_t;

	typedef struct packed {
		logic signed [31:0] angle;
		logic               tag;
	} cord_out_t;
endpackage
`default_nettype wire

FILE: src/rmea_sqrt.sv
// Pipelined integer square root, one result bit per stage, matrix carried alongside
`default_nettype none
module rmea_sqrt (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [63:0]       radicand,
	input  rmea_pkg::matrix_t in_mat,
	output logic              out_valid,
	output logic [31:0]       root,
	output rmea_pkg::matrix_t out_mat
);
	import rmea_pkg::*;

	logic [63:0] n_s [1:SQRT_STEPS];
	logic [63:0] r_s [1:SQRT_STEPS];
	matrix_t     m_s [1:SQRT_STEPS];
	logic        v_s [1:SQRT_STEPS];

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
		localparam logic [63:0] BIT = 64'(1) << (62 - 2 * k);
		logic [63:0] n_cur;
		logic [63:0] r_cur;
		matrix_t     m_cur;
		logic        v_cur;
		logic [63:0] trial;

		if (k == 0) begin : g_first
			assign n_cur = radicand;
			assign r_cur = '0;
			assign m_cur = in_mat;
			assign v_cur = in_valid;
		end else begin : g_rest
			assign n_cur = n_s[k];
			assign r_cur = r_s[k];
			assign m_cur = m_s[k];
			assign v_cur = v_s[k];
		end

		assign trial = r_cur + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_cur;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				m_s[k+1] <= m_cur;
				if (n_cur >= trial) begin
					n_s[k+1] <= n_cur - trial;
					r_s[k+1] <= (r_cur >> 1) + BIT;
				end else begin
					n_s[k+1] <= n_cur;
					r_s[k+1] <= r_cur >> 1;
				end
			end
		end
	end

	assign out_valid = v_s[SQRT_STEPS];
	assign root      = r_s[SQRT_STEPS][31:0];
	assign out_mat   = m_s[SQRT_STEPS];
endmodule
`default_nettype wire

FILE: src/rmea_cordic.sv
// Pipelined CORDIC atan2: quadrant fold, 30 vectoring stages, round and clamp
`default_nettype none
module rmea_cordic (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  rmea_pkg::cord_in_t  op,
	output logic                out_valid,
	output rmea_pkg::cord_out_t res
);
	import rmea_pkg::*;

	logic signed [CW-1:0] x_s   [0:CORDIC_STEPS];
	logic signed [CW-1:0] y_s   [0:CORDIC_STEPS];
	logic signed [AW-1:0] ang_s [0:CORDIC_STEPS];
	logic                 z_s   [0:CORDIC_STEPS];
	logic                 t_s   [0:CORDIC_STEPS];
	logic                 v_s   [0:CORDIC_STEPS];

	logic signed [CW-1:0] xe;
	logic signed [CW-1:0] ye;
	logic signed [AW:0]   rnd;
	logic signed [AW-1:0] half;

	// operands scaled by 2^20
	assign xe = {{3{op.x[32]}}, op.x, 20'b0};
	assign ye = {{3{op.y[32]}}, op.y, 20'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s[0] <= (op.x == '0) && (op.y == '0);
			t_s[0] <= op.tag;
			if (op.x < 0) begin
				x_s[0]   <= -xe;
				y_s[0]   <= -ye;
				ang_s[0] <= (op.y >= 0) ? PI_Q30 : -PI_Q30;
			end else begin
				x_s[0]   <= xe;
				y_s[0]   <= ye;
				ang_s[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		localparam logic signed [AW-1:0] T = AW'(ATAN_TAB[i]);
		logic signed [CW-1:0] xs;
		logic signed [CW-1:0] ys;

		assign xs = x_s[i] >>> i;
		assign ys = y_s[i] >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				z_s[i+1] <= z_s[i];
				t_s[i+1] <= t_s[i];
				if (y_s[i] >= 0) begin
					x_s[i+1]   <= x_s[i] + ys;
					y_s[i+1]   <= y_s[i] - xs;
					ang_s[i+1] <= ang_s[i] + T;
				end else begin
					x_s[i+1]   <= x_s[i] - ys;
					y_s[i+1]   <= y_s[i] + xs;
					ang_s[i+1] <= ang_s[i] - T;
				end
			end
		end
	end

	// Q2.30 to Q3.29, rounding half up
	assign rnd  = (AW+1)'(ang_s[CORDIC_STEPS]) + (AW+1)'(1);
	assign half = rnd[AW:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v_s[CORDIC_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res.tag <= t_s[CORDIC_STEPS];
			if (z_s[CORDIC_STEPS]) begin
				res.angle <= '0;
			end else if (half > AW'(ANG_MAX)) begin
				res.angle <= ANG_MAX;
			end else if (half < -AW'(ANG_MAX)) begin
				res.angle <= -ANG_MAX;
			end else begin
				res.angle <= half[31:0];
			end
		end
	end
endmodule
`default_nettype wire

FILE: src/rotation_matrix_to_euler_angles.sv
// Rotation matrix to x-y-z Euler angles: top level with multiply, root and CORDIC pipeline
//
// Takes seven entries of a rotation matrix (Q2.30) and returns the x, y and z Euler angles
// (Q3.29 radians) plus a gimbal-lock flag. One matrix is accepted every clock cycle while the
// pipeline is not frozen; each result passes through one squaring stage, one add stage,
// 32 square-root digit stages, one operand select stage and 32 CORDIC stages (fold,
// 30 rotations, round/clamp). The whole pipeline advances together and freezes while a
// finished result waits on angles_ready. singular_threshold may be written at any time the
// block is idle; it resets to 1074 (about 1e-6).
`default_nettype none
`include "rotation_matrix_to_euler_angles_defines.svh"
module rotation_matrix_to_euler_angles (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              matrix_valid,
	output logic              matrix_ready,
	input  rmea_pkg::matrix_t matrix,
	output logic              angles_valid,
	input  logic              angles_ready,
	output rmea_pkg::angles_t angles,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [30:0]       cfg_data
);
	import rmea_pkg::*;

	logic        adv;
	logic [30:0] thr_q;

	logic        v_s1;
	logic [63:0] sq0_s1;
	logic [63:0] sq1_s1;
	matrix_t     m_s1;
	logic signed [63:0] p0;
	logic signed [63:0] p1;

	logic        v_s2;
	logic [63:0] sum_s2;
	matrix_t     m_s2;

	logic        rt_valid;
	logic [31:0] sy;
	matrix_t     rt_mat;

	logic        v_s3;
	cord_in_t    opx_s3;
	cord_in_t    opy_s3;
	cord_in_t    opz_s3;

	logic        sing;
	logic signed [32:0] r20e;
	logic signed [32:0] r12e;

	logic        cx_valid;
	logic        cy_valid;
	logic        cz_valid;
	cord_out_t   cx_res;
	cord_out_t   cy_res;
	cord_out_t   cz_res;

	assign adv          = !angles_valid || angles_ready;
	assign matrix_ready = adv;
	assign cfg_ready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_valid) begin
			thr_q <= cfg_data;
		end
	end

	assign p0 = matrix.r00 * matrix.r00;
	assign p1 = matrix.r10 * matrix.r10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= matrix_valid;
			v_s2 <= v_s1;
			v_s3 <= rt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq0_s1 <= p0;
			sq1_s1 <= p1;
			m_s1   <= matrix;
			sum_s2 <= sq0_s1 + sq1_s1;
			m_s2   <= m_s1;
		end
	end

	rmea_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_s2),
		.radicand (sum_s2),
		.in_mat   (m_s2),
		.out_valid(rt_valid),
		.root     (sy),
		.out_mat  (rt_mat)
	);

	assign sing = sy < {1'b0, thr_q};
	assign r20e = 33'(rt_mat.r20);
	assign r12e = 33'(rt_mat.r12);

	// singular: x from r12/r11, z operands zeroed so its atan2 gives zero
	always_ff @(posedge clk) begin
		if (adv) begin
			opy_s3.y   <= -r20e;
			opy_s3.x   <= {1'b0, sy};
			opy_s3.tag <= sing;
			opx_s3.tag <= 1'b0;
			opz_s3.tag <= 1'b0;
			if (sing) begin
				opx_s3.y <= -r12e;
				opx_s3.x <= 33'(rt_mat.r11);
				opz_s3.y <= '0;
				opz_s3.x <= '0;
			end else begin
				opx_s3.y <= 33'(rt_mat.r21);
				opx_s3.x <= 33'(rt_mat.r22);
				opz_s3.y <= 33'(rt_mat.r10);
				opz_s3.x <= 33'(rt_mat.r00);
			end
		end
	end

	rmea_cordic u_cordic_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_s3),
		.op       (opx_s3),
		.out_valid(cx_valid),
		.res      (cx_res)
	);

	rmea_cordic u_cordic_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_s3),
		.op       (opy_s3),
		.out_valid(cy_valid),
		.res      (cy_res)
	);

	rmea_cordic u_cordic_z (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_s3),
		.op       (opz_s3),
		.out_valid(cz_valid),
		.res      (cz_res)
	);

	assign angles_valid     = cy_valid;
	assign angles.angle_x   = cx_res.angle;
	assign angles.angle_y   = cy_res.angle;
	assign angles.angle_z   = cz_res.angle;
	assign angles.singular  = cy_res.tag;

	`RMEA_ASSERT_NEXT(a_stall_keeps, clk, arst_n, angles_valid && !angles_ready,
		angles_valid && $stable(angles), "stalled transaction changed or dropped")
	`RMEA_ASSERT_NOW(a_lanes_agree, clk, arst_n, 1'b1,
		(cx_valid == cy_valid) && (cz_valid == cy_valid), "CORDIC lanes out of step")
	`RMEA_ASSERT_NOW(a_sing_z_zero, clk, arst_n, angles_valid && angles.singular,
		angles.angle_z == '0, "angle_z nonzero in singular transaction")
	`RMEA_ASSERT_NOW(a_y_range, clk, arst_n, angles_valid,
		(angles.angle_y <= ANG_MAX) && (angles.angle_y >= -ANG_MAX), "angle_y out of range")
endmodule
`default_nettype wire

FILE: bench/rotation_matrix_to_euler_angles_test.sv
// Testbench for the rotation matrix to Euler angles block: directed and random matrices
`default_nettype none
module rotation_matrix_to_euler_angles_test;
	import rmea_pkg::*;

	localparam int PIPE_LAT = 67;

	logic clk = 0;
	logic arst_n = 0;
	logic matrix_valid = 0;
	logic matrix_ready;
	matrix_t matrix = '0;
	logic angles_valid;
	logic angles_ready = 0;
	angles_t angles;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [30:0] cfg_data = '0;

	angles_t expected_angles[$];
	logic [30:0] threshold_q = THR_RESET;
	int failures = 0;
	int rx_mode = 0;
	logic hold_req = 0;
	int hold_left = 0;
	int rx_phase = 0;
	int burst_left = 0;

	rotation_matrix_to_euler_angles uut (
		.clk(clk), .arst_n(arst_n),
		.matrix_valid(matrix_valid), .matrix_ready(matrix_ready), .matrix(matrix),
		.angles_valid(angles_valid), .angles_ready(angles_ready), .angles(angles),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// CORDIC vectoring atan2, Q2.30 internally, Q3.29 out
	function automatic logic signed [31:0] cordic_atan2(longint y, longint x);
		longint ang;
		longint xs;
		longint ys;
		ang = 0;
		if (x == 0 && y == 0)
			return 0;
		x = x * 1048576;
		y = y * 1048576;
		if (x < 0) begin
			ang = (y >= 0) ? longint'(PI_Q30) : -longint'(PI_Q30);
			x = -x;
			y = -y;
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				ang = ang + longint'(ATAN_TAB[i]);
			end else begin
				x = x - ys;
				y = y + xs;
				ang = ang - longint'(ATAN_TAB[i]);
			end
		end
		ang = (ang + 1) >>> 1;
		if (ang > longint'(ANG_MAX))
			ang = ANG_MAX;
		if (ang < -longint'(ANG_MAX))
			ang = -longint'(ANG_MAX);
		return ang[31:0];
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n)
			b = b >> 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n = n - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic angles_t euler_predict(matrix_t m);
		angles_t a;
		longint r00, r10, r11, r12, r20, r21, r22, sy;
		longint unsigned sq;
		r00 = m.r00; r10 = m.r10; r11 = m.r11; r12 = m.r12;
		r20 = m.r20; r21 = m.r21; r22 = m.r22;
		sq = longint'(r00 * r00) + longint'(r10 * r10);
		sy = int_sqrt(sq);
		a.singular = sy < longint'(threshold_q);
		a.angle_y = cordic_atan2(-r20, sy);
		if (!a.singular) begin
			a.angle_x = cordic_atan2(r21, r22);
			a.angle_z = cordic_atan2(r10, r00);
		end else begin
			a.angle_x = cordic_atan2(-r12, r11);
			a.angle_z = 0;
		end
		return a;
	endfunction

	// receiver: long hold-off on request, otherwise a stall pattern per mode
	always @(posedge clk) begin
		rx_phase <= rx_phase + 1;
		if (hold_req) begin
			hold_left = 300;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			angles_ready <= 0;
		end else if (rx_mode == 0) begin
			angles_ready <= 1;
		end else if (rx_mode == 1) begin
			angles_ready <= $urandom_range(0, 3) != 0;
		end else begin
			angles_ready <= (rx_phase % 11) < 6;
		end
	end

	// result checker: a transaction completes at the next rising edge
	always @(negedge clk) begin
		angles_t exp_a;
		if (arst_n && angles_valid && angles_ready) begin
			if (expected_angles.size() == 0) begin
				$error("unexpected result angles=%h", angles);
				failures++;
			end else begin
				exp_a = expected_angles.pop_front();
				if (angles.angle_x !== exp_a.angle_x) begin
					$error("angle_x expected %0d actual %0d", exp_a.angle_x, angles.angle_x);
					failures++;
				end
				if (angles.angle_y !== exp_a.angle_y) begin
					$error("angle_y expected %0d actual %0d", exp_a.angle_y, angles.angle_y);
					failures++;
				end
				if (angles.angle_z !== exp_a.angle_z) begin
					$error("angle_z expected %0d actual %0d", exp_a.angle_z, angles.angle_z);
					failures++;
				end
				if (angles.singular !== exp_a.singular) begin
					$error("singular expected %0b actual %0b", exp_a.singular, angles.singular);
					failures++;
				end
			end
		end
	end

	task automatic send_matrix(matrix_t m);
		logic ok;
		matrix_valid <= 1;
		matrix <= m;
		do begin
			@(negedge clk);
			ok = matrix_ready;
			@(posedge clk);
		end while (!ok);
		expected_angles.insert(expected_angles.size(), euler_predict(m));
	endtask

	task automatic idle_cycles(int n);
		matrix_valid <= 0;
		repeat (n) @(posedge clk);
	endtask

	// bursty sender
	task automatic send_flow(matrix_t m, bit gaps);
		if (gaps && burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			idle_cycles($urandom_range(1, 8));
		end
		if (burst_left > 0)
			burst_left--;
		send_matrix(m);
	endtask

	task automatic drain;
		matrix_valid <= 0;
		while (expected_angles.size() != 0)
			@(posedge clk);
		repeat (PIPE_LAT + 5) @(posedge clk);
	endtask

	task automatic write_threshold(logic [30:0] v);
		logic ok;
		drain();
		cfg_valid <= 1;
		cfg_data <= v;
		do begin
			@(negedge clk);
			ok = cfg_ready;
			@(posedge clk);
		end while (!ok);
		cfg_valid <= 0;
		threshold_q = v;
	endtask

	function automatic logic signed [31:0] to_q30(real v);
		return $rtoi(v * 1073741824.0);
	endfunction

	function automatic real rand_angle(real span);
		return ($urandom / 4294967296.0 * 2.0 - 1.0) * span;
	endfunction

	function automatic matrix_t rotation(real ax, real ay, real az);
		matrix_t m;
		real sx, cx, sy, cy, sz, cz;
		sx = $sin(ax); cx = $cos(ax);
		sy = $sin(ay); cy = $cos(ay);
		sz = $sin(az); cz = $cos(az);
		m.r00 = to_q30(cy * cz);
		m.r10 = to_q30(cy * sz);
		m.r20 = to_q30(-sy);
		m.r11 = to_q30(sx * sy * sz + cx * cz);
		m.r12 = to_q30(cx * sy * sz - sx * cz);
		m.r21 = to_q30(cy * sx);
		m.r22 = to_q30(cy * cx);
		return m;
	endfunction

	function automatic matrix_t random_words();
		matrix_t m;
		m.r00 = $urandom; m.r10 = $urandom; m.r11 = $urandom; m.r12 = $urandom;
		m.r20 = $urandom; m.r21 = $urandom; m.r22 = $urandom;
		return m;
	endfunction

	task automatic test_directed;
		localparam logic signed [31:0] ONE = 32'sd1073741824;
		localparam logic signed [31:0] MINV = 32'sh80000000;
		localparam logic signed [31:0] MAXV = 32'sh7fffffff;
		rx_mode = 0;
		send_matrix('0);                                     // all atan2 operands zero
		send_matrix('{ONE, 0, ONE, 0, 0, 0, ONE});            // identity
		send_matrix('{-ONE, 0, -ONE, 0, 0, 0, -ONE});
		send_matrix('{0, 0, ONE, 0, -ONE, 0, 0});             // gimbal lock, y = +pi/2
		send_matrix('{0, 0, 0, -ONE, ONE, ONE, 0});           // gimbal lock, y = -pi/2
		send_matrix('{0, 0, -ONE, ONE, 0, 0, 0});
		send_matrix('{MINV, MINV, MINV, MINV, MINV, MINV, MINV});
		send_matrix('{MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV});
		send_matrix('{MINV, 0, MAXV, MINV, MAXV, MINV, MAXV});
		send_matrix('{-1, 0, 0, 0, 0, 0, -1});                // r00 < 0, r10 = 0; sy under threshold, so singular
		send_matrix('{-1, -1, 1, 1, 1, -1, -1});
		send_matrix('{1, 0, 0, 0, 0, 0, 0});
		send_matrix('{0, 1, 0, 0, 0, 1, 0});
		send_matrix('{1074, 0, ONE, 0, 0, 0, 1});             // sy at threshold
		send_matrix('{1073, 0, ONE, 0, 0, 0, 1});             // just below
		send_matrix(rotation(1.0, 0.5, -2.0));
		send_matrix(rotation(-3.1, -1.2, 3.1));
		drain();
	endtask

	task automatic test_thresholds;
		logic [30:0] settings[5] = '{31'd0, 31'd1073741824, 31'h7fffffff, 31'd50000, 31'd1};
		foreach (settings[k]) begin
			write_threshold(settings[k]);
			rx_mode = k % 3;
			for (int i = 0; i < 12; i++)
				send_flow(i % 3 == 0 ? random_words() :
					rotation(rand_angle(3.14), rand_angle(1.57), rand_angle(3.14)), 1);
			send_matrix('{1, 0, 1, 1, 1, 1, 1});
		end
		write_threshold(THR_RESET);
	endtask

	task automatic test_random_rotations;
		real ay;
		for (int i = 0; i < 320; i++) begin
			if (i % 100 == 0)
				rx_mode = (i / 100) % 3;
			if ($urandom_range(0, 9) == 0)
				ay = ($urandom_range(0, 1) ? 1.5707963267948966 : -1.5707963267948966)
					+ rand_angle(1.0e-5);
			else
				ay = rand_angle(1.5707963);
			send_flow(rotation(rand_angle(3.14159), ay, rand_angle(3.14159)), i >= 200);
		end
		drain();
	endtask

	task automatic test_random_words;
		rx_mode = 1;
		for (int i = 0; i < 150; i++)
			send_flow(random_words(), 1);
		drain();
	endtask

	task automatic test_backpressure;
		rx_mode = 0;
		hold_req = 1;
		for (int i = 0; i < 100; i++)
			send_matrix(rotation(rand_angle(3.0), rand_angle(1.5), rand_angle(3.0)));
		drain();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_thresholds();
		test_random_rotations();
		test_random_words();
		test_backpressure();
		drain();
		if (failures == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#2000000;
		$display("Regression FAIL");
		$finish;
	end
endmodule
`default_nettype wire

FILE: rotation_matrix_to_euler_angles.f
+incdir+src
src/rmea_pkg.sv
src/rmea_sqrt.sv
src/rmea_cordic.sv
src/rotation_matrix_to_euler_angles.sv
bench/rotation_matrix_to_euler_angles_test.sv
